FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dfr_pkg.sv
package dfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam int APB_ADDR_W = 4;

    // register indexes
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_LEN     = 2'd2;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [6:0] MAX_LEN_RST     = 7'd64;

    // result kinds
    localparam logic [1:0] KIND_READY   = 2'd0;
    localparam logic [1:0] KIND_LEN_ERR = 2'd1;
    localparam logic [1:0] KIND_CRC_ERR = 2'd2;

    localparam logic [2:0]  HDR_LAST  = 3'd5;
    localparam logic [15:0] CNT_MAX   = 16'hFFFF;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_MSB   = 16'h8000;

    typedef struct packed {
        logic sync_ok;
        logic hdr_wr;
        logic pay_wr;
        logic crclo_wr;
        logic emit_len;
        logic emit_crc;
        logic emit_empty;
        logic drain_init;
        logic drain_rd;
        logic drain_emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic hdr_last;
        logic len_big;
        logic len_zero;
        logic pay_done;
        logic crc_ok;
        logic cnt_zero;
        logic drain_last;
        logic out_free;
    } t_dp_sts;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/dfr_ctrl.sv
`include "assert_macros.svh"

module dfr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dfr_pkg::t_dp_sts i_sts,
    output dfr_pkg::t_dp_cmd o_cmd
);
    import dfr_pkg::*;

    typedef enum logic [7:0] {
        ST_HUNT1     = 8'b0000_0001,
        ST_HUNT2     = 8'b0000_0010,
        ST_HEADER    = 8'b0000_0100,
        ST_PAYLOAD   = 8'b0000_1000,
        ST_CRCLO     = 8'b0001_0000,
        ST_CRCHI     = 8'b0010_0000,
        ST_DRAIN_RD  = 8'b0100_0000,
        ST_DRAIN_OUT = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_fire;
    logic   draining;
    logic   may_emit;

    assign draining   = (r_state == ST_DRAIN_RD) || (r_state == ST_DRAIN_OUT);
    // only a byte that can load a result has to wait for the output register
    assign may_emit   = ((r_state == ST_HEADER) && i_sts.hdr_last) || (r_state == ST_CRCHI);
    assign o_in_ready = !draining && (!may_emit || i_sts.out_free);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_HUNT1: begin
                if (in_fire && i_sts.is_sync1) begin
                    n_state = ST_HUNT2;
                end
            end
            ST_HUNT2: begin
                if (in_fire) begin
                    if (i_sts.is_sync2) begin
                        o_cmd.sync_ok = 1'b1;
                        n_state       = ST_HEADER;
                    end else if (!i_sts.is_sync1) begin
                        n_state = ST_HUNT1;
                    end
                end
            end
            ST_HEADER: begin
                if (in_fire) begin
                    o_cmd.hdr_wr = 1'b1;
                    if (i_sts.hdr_last) begin
                        priority if (i_sts.len_big) begin
                            o_cmd.emit_len = 1'b1;
                            n_state        = ST_HUNT1;
                        end else if (i_sts.len_zero) begin
                            n_state = ST_CRCLO;
                        end else begin
                            n_state = ST_PAYLOAD;
                        end
                    end
                end
            end
            ST_PAYLOAD: begin
                if (in_fire) begin
                    o_cmd.pay_wr = 1'b1;
                    if (i_sts.pay_done) begin
                        n_state = ST_CRCLO;
                    end
                end
            end
            ST_CRCLO: begin
                if (in_fire) begin
                    o_cmd.crclo_wr = 1'b1;
                    n_state        = ST_CRCHI;
                end
            end
            ST_CRCHI: begin
                if (in_fire) begin
                    priority if (!i_sts.crc_ok) begin
                        o_cmd.emit_crc = 1'b1;
                        n_state        = ST_HUNT1;
                    end else if (i_sts.cnt_zero) begin
                        o_cmd.emit_empty = 1'b1;
                        n_state          = ST_HUNT1;
                    end else begin
                        o_cmd.drain_init = 1'b1;
                        n_state          = ST_DRAIN_RD;
                    end
                end
            end
            ST_DRAIN_RD: begin
                o_cmd.drain_rd = 1'b1;
                n_state        = ST_DRAIN_OUT;
            end
            ST_DRAIN_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.drain_emit = 1'b1;
                    n_state = i_sts.drain_last ? ST_HUNT1 : ST_DRAIN_RD;
                end
            end
            default: begin
                n_state = ST_HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT1;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_ALWAYS(a_one_emit, i_clk, i_rst_n,
        $onehot0({o_cmd.emit_len, o_cmd.emit_crc, o_cmd.emit_empty, o_cmd.drain_emit}),
        "more than one result loaded in a cycle")
    `ASSERT_IMPLIES(a_emit_free, i_clk, i_rst_n,
        o_cmd.emit_len || o_cmd.emit_crc || o_cmd.emit_empty || o_cmd.drain_emit,
        i_sts.out_free, "result loaded while output register busy")
    `ASSERT_NEXT(a_drain_seq, i_clk, i_rst_n, r_state == ST_DRAIN_RD,
        r_state == ST_DRAIN_OUT, "drain read not followed by output step")

endmodule

FILE: rtl/core/dfr_datapath.sv
`include "assert_macros.svh"

module dfr_datapath #(
    parameter int MAX_PAYLOAD = dfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_rx_byte,
    input  logic [7:0]       i_sync_first,
    input  logic [7:0]       i_sync_second,
    input  logic [6:0]       i_max_len,
    input  dfr_pkg::t_dp_cmd i_cmd,
    output dfr_pkg::t_dp_sts o_sts,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [1:0]       o_event_kind,
    output logic [7:0]       o_version,
    output logic [7:0]       o_frame_type,
    output logic [7:0]       o_sequence_res,
    output logic [7:0]       o_command,
    output logic [6:0]       o_payload_length,
    output logic [7:0]       o_payload_byte,
    output logic             o_payload_byte_valid,
    output logic             o_last,
    output logic [15:0]      o_length_error_count,
    output logic [15:0]      o_crc_error_count
);
    import dfr_pkg::*;

    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [6:0] LIM_MAX = 7'(MAX_PAYLOAD);

    logic [2:0]    r_hidx;
    logic [7:0]    r_hdr [0:5];
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_didx;
    logic [15:0]   r_crc;
    logic [7:0]    r_crclo;
    logic [15:0]   r_lerr;
    logic [15:0]   r_cerr;
    logic [7:0]    r_mem [0:MAX_PAYLOAD-1];
    logic [7:0]    r_rd_data;
    logic          r_o_valid;

    logic [15:0]   len16;
    logic [6:0]    lim;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] didx_inc;
    logic [15:0]   crc_next;
    logic [15:0]   n_lerr;
    logic [15:0]   n_cerr;
    logic          emit_any;

    assign len16    = {i_rx_byte, r_hdr[4]};
    assign lim      = (i_max_len > LIM_MAX) ? LIM_MAX : i_max_len;
    assign cnt_inc  = r_cnt + CW'(1);
    assign didx_inc = r_didx + CW'(1);
    assign crc_next = crc16_byte(r_crc, i_rx_byte);
    assign n_lerr   = (r_lerr != CNT_MAX) ? r_lerr + 16'd1 : r_lerr;
    assign n_cerr   = (r_cerr != CNT_MAX) ? r_cerr + 16'd1 : r_cerr;
    assign emit_any = i_cmd.emit_len || i_cmd.emit_crc || i_cmd.emit_empty || i_cmd.drain_emit;

    always_comb begin
        o_sts.is_sync1   = (i_rx_byte == i_sync_first);
        o_sts.is_sync2   = (i_rx_byte == i_sync_second);
        o_sts.hdr_last   = (r_hidx == HDR_LAST);
        o_sts.len_big    = (len16 > {9'd0, lim});
        o_sts.len_zero   = (len16 == 16'd0);
        o_sts.pay_done   = (cnt_inc >= r_len);
        o_sts.crc_ok     = ({i_rx_byte, r_crclo} == r_crc);
        o_sts.cnt_zero   = (r_cnt == '0);
        o_sts.drain_last = (didx_inc == r_cnt);
        o_sts.out_free   = !r_o_valid || i_out_ready;
    end

    // frame control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidx    <= '0;
            r_cnt     <= '0;
            r_didx    <= '0;
            r_crc     <= CRC_INIT;
            r_lerr    <= '0;
            r_cerr    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.sync_ok) begin
                r_hidx <= '0;
                r_crc  <= CRC_INIT;
            end
            if (i_cmd.hdr_wr) begin
                r_hidx <= r_hidx + 3'd1;
                r_crc  <= crc_next;
                if (r_hidx == HDR_LAST) begin
                    r_cnt <= '0;
                end
            end
            if (i_cmd.pay_wr) begin
                r_cnt <= cnt_inc;
                r_crc <= crc_next;
            end
            if (i_cmd.drain_init) begin
                r_didx <= '0;
            end
            if (i_cmd.drain_emit) begin
                r_didx <= didx_inc;
            end
            if (i_cmd.emit_len) begin
                r_lerr <= n_lerr;
            end
            if (i_cmd.emit_crc) begin
                r_cerr <= n_cerr;
            end
            if (emit_any) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // header bytes, length, crc low byte, result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.hdr_wr) begin
            r_hdr[r_hidx] <= i_rx_byte;
            if (r_hidx == HDR_LAST) begin
                r_len <= len16[CW-1:0];
            end
        end
        if (i_cmd.crclo_wr) begin
            r_crclo <= i_rx_byte;
        end
        if (i_cmd.emit_len || i_cmd.emit_crc) begin
            o_event_kind         <= i_cmd.emit_len ? KIND_LEN_ERR : KIND_CRC_ERR;
            o_version            <= '0;
            o_frame_type         <= '0;
            o_sequence_res       <= '0;
            o_command            <= '0;
            o_payload_length     <= '0;
            o_payload_byte       <= '0;
            o_payload_byte_valid <= 1'b0;
            o_last               <= 1'b1;
            o_length_error_count <= i_cmd.emit_len ? n_lerr : r_lerr;
            o_crc_error_count    <= i_cmd.emit_crc ? n_cerr : r_cerr;
        end else if (i_cmd.emit_empty || i_cmd.drain_emit) begin
            o_event_kind         <= KIND_READY;
            o_version            <= r_hdr[0];
            o_frame_type         <= r_hdr[1];
            o_sequence_res       <= r_hdr[2];
            o_command            <= r_hdr[3];
            o_payload_length     <= 7'(r_cnt);
            o_payload_byte       <= i_cmd.drain_emit ? r_rd_data : 8'h00;
            o_payload_byte_valid <= i_cmd.drain_emit;
            o_last               <= i_cmd.emit_empty || o_sts.drain_last;
            o_length_error_count <= r_lerr;
            o_crc_error_count    <= r_cerr;
        end
    end

    // payload buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.pay_wr) begin
            r_mem[r_cnt[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.drain_rd) begin
            r_rd_data <= r_mem[r_didx[AW-1:0]];
        end
    end

    assign o_out_valid = r_o_valid;

    `ASSERT_IMPLIES(a_drain_range, i_clk, i_rst_n, i_cmd.drain_rd || i_cmd.drain_emit,
        r_didx < r_cnt, "drain index beyond stored payload")

endmodule

FILE: rtl/core/stream_frame_deframer_crc16.sv
// Sync-framed byte deframer with CRC-16/CCITT-FALSE check.
// Throughput: one received byte per cycle while not draining; only the last header byte
// and the CRC high byte wait while the output register holds a result not yet taken.
// Latency: error or empty-frame result is valid in the cycle after its last byte is taken.
// A good frame drains each payload byte (read, then load once output is free); no input meanwhile.
// Reset (synchronous, active low): hunting first sync byte, counters zero, config registers default.
module stream_frame_deframer_crc16 #(
    parameter int MAX_PAYLOAD = dfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_event_kind,
    output logic [7:0]                     o_version,
    output logic [7:0]                     o_frame_type,
    output logic [7:0]                     o_sequence_res,
    output logic [7:0]                     o_command,
    output logic [6:0]                     o_payload_length,
    output logic [7:0]                     o_payload_byte,
    output logic                           o_payload_byte_valid,
    output logic                           o_last,
    output logic [15:0]                    o_length_error_count,
    output logic [15:0]                    o_crc_error_count,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dfr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import dfr_pkg::*;

    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic [6:0] r_max_len;
    logic       cfg_wr;
    logic [1:0] cfg_idx;
    t_dp_cmd    cmd;
    t_dp_sts    sts;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_max_len     <= MAX_LEN_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SYNC_FIRST:  r_sync_first  <= pwdata[7:0];
                REG_SYNC_SECOND: r_sync_second <= pwdata[7:0];
                REG_MAX_LEN:     r_max_len     <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SYNC_FIRST:  prdata = {24'd0, r_sync_first};
            REG_SYNC_SECOND: prdata = {24'd0, r_sync_second};
            REG_MAX_LEN:     prdata = {25'd0, r_max_len};
            default:         prdata = '0;
        endcase
    end

    dfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dfr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_rx_byte            (i_rx_byte),
        .i_sync_first         (r_sync_first),
        .i_sync_second        (r_sync_second),
        .i_max_len            (r_max_len),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_out_ready          (i_out_ready),
        .o_out_valid          (o_out_valid),
        .o_event_kind         (o_event_kind),
        .o_version            (o_version),
        .o_frame_type         (o_frame_type),
        .o_sequence_res       (o_sequence_res),
        .o_command            (o_command),
        .o_payload_length     (o_payload_length),
        .o_payload_byte       (o_payload_byte),
        .o_payload_byte_valid (o_payload_byte_valid),
        .o_last               (o_last),
        .o_length_error_count (o_length_error_count),
        .o_crc_error_count    (o_crc_error_count)
    );

endmodule
